// ===== rtl/core/bsg_pkg.sv =====
// Package for the battery state-of-charge gauge: widths, register indexes,
// the job type between front and back, and the fixed discharge curve.
// No dependencies; every other file uses it by scoped names.
`default_nettype none

package bsg_pkg;

  // Field and state widths.
  localparam int SAMPLE_BITS  = 11;
  localparam int MAX_AVERAGE  = 8;
  localparam int TABLE_POINTS = 15;
  localparam int SUM_W        = 15;
  localparam int CNT_W        = 4;
  localparam int SPR_W        = 4;
  localparam int SCALE_W      = 20;
  localparam int MV_W         = 14;
  localparam int SOC_W        = 7;
  localparam int AVG_W        = 13;
  localparam int PROD_W       = AVG_W + SCALE_W;
  localparam int DIV_W        = 19;
  localparam int STEP_W       = 4;
  localparam int SEG_W        = 4;
  localparam int SEGMENTS     = TABLE_POINTS - 1;
  localparam int TENTHS_W     = 10;
  localparam int DX_W         = 8;
  localparam int NUM_W        = 18;

  // Divider shapes: quotient bits for the average and for the charge.
  localparam int AVG_STEPS = AVG_W;
  localparam int SOC_STEPS = 7;

  localparam logic [MV_W-1:0]  MV_MAX  = MV_W'(16383);
  localparam logic [SOC_W-1:0] SOC_MAX = SOC_W'(100);

  // Configuration register indexes.
  localparam logic REG_SAMPLES = 1'b0;
  localparam logic REG_SCALE   = 1'b1;

  localparam logic [SPR_W-1:0]   SPR_RESET   = SPR_W'(5);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(360300);

  // One completed accumulation handed from the front to the back.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SPR_W-1:0]        count;
  } job_t;

  // Discharge curve voltages; points past the last repeat the last.
  function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] v;
    case (idx)
      4'd0:    v = 14'd3000;
      4'd1:    v = 14'd3200;
      4'd2:    v = 14'd3300;
      4'd3:    v = 14'd3400;
      4'd4:    v = 14'd3500;
      4'd5:    v = 14'd3550;
      4'd6:    v = 14'd3600;
      4'd7:    v = 14'd3650;
      4'd8:    v = 14'd3700;
      4'd9:    v = 14'd3800;
      4'd10:   v = 14'd3900;
      4'd11:   v = 14'd4050;
      4'd12:   v = 14'd4100;
      4'd13:   v = 14'd4150;
      default: v = 14'd4200;
    endcase
    return v;
  endfunction

  // Discharge curve charge in tenths of a percent.
  function automatic logic [TENTHS_W-1:0] curve_tenths(input logic [SEG_W-1:0] idx);
    logic [TENTHS_W-1:0] v;
    case (idx)
      4'd0:    v = 10'd0;
      4'd1:    v = 10'd20;
      4'd2:    v = 10'd37;
      4'd3:    v = 10'd62;
      4'd4:    v = 10'd120;
      4'd5:    v = 10'd177;
      4'd6:    v = 10'd255;
      4'd7:    v = 10'd370;
      4'd8:    v = 10'd485;
      4'd9:    v = 10'd650;
      4'd10:   v = 10'd760;
      4'd11:   v = 10'd893;
      4'd12:   v = 10'd930;
      4'd13:   v = 10'd970;
      default: v = 10'd1000;
    endcase
    return v;
  endfunction

  // Voltage span of a segment.
  function automatic logic [DX_W-1:0] seg_dx(input logic [SEG_W-1:0] seg);
    logic [MV_W-1:0] diff;
    diff = curve_mv(seg + SEG_W'(1)) - curve_mv(seg);
    return diff[DX_W-1:0];
  endfunction

  // Charge rise over a segment.
  function automatic logic [TENTHS_W-1:0] seg_dy(input logic [SEG_W-1:0] seg);
    return curve_tenths(seg + SEG_W'(1)) - curve_tenths(seg);
  endfunction

  // Start charge times span: the constant part of the numerator.
  function automatic logic [NUM_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
    return NUM_W'(curve_tenths(seg)) * NUM_W'(seg_dx(seg));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bsg_queue.sv =====
// Two-entry job queue between the sample front end and the compute back end.
// Depends on bsg_pkg for the job type.
`default_nettype none

module bsg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bsg_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output bsg_pkg::job_t      pop_data,
  output logic               empty
);

  bsg_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) fill <= fill + 2'd1;
      else if (do_pop && !do_push) fill <= fill - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== rtl/core/bsg_front.sv =====
// Front end of the gauge: takes samples, sums them and hands off a job
// each time the averaging count is reached. Depends on bsg_pkg.
`default_nettype none

module bsg_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  input  wire logic signed [bsg_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                     full,
  input  wire logic [bsg_pkg::SPR_W-1:0]           samples_per_result,
  output logic                                     job_push,
  output bsg_pkg::job_t                            job_data,
  input  wire logic                                job_full
);

  logic signed [bsg_pkg::SUM_W-1:0] sample_sum;
  logic signed [bsg_pkg::SUM_W-1:0] sample_sum_next;
  logic [bsg_pkg::CNT_W-1:0]        sample_count;
  logic [bsg_pkg::CNT_W-1:0]        sample_count_next;
  logic [bsg_pkg::SPR_W-1:0]        n_eff;
  logic                             accept;
  logic                             complete;

  // Zero acts as one, and anything above the limit acts as the limit.
  always_comb begin
    if (samples_per_result == '0) n_eff = bsg_pkg::SPR_W'(1);
    else if (samples_per_result > bsg_pkg::SPR_W'(bsg_pkg::MAX_AVERAGE))
      n_eff = bsg_pkg::SPR_W'(bsg_pkg::MAX_AVERAGE);
    else n_eff = samples_per_result;
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  // Running sum and count including the incoming sample.
  assign sample_sum_next   = sample_sum + bsg_pkg::SUM_W'(sample);
  assign sample_count_next = sample_count + bsg_pkg::CNT_W'(1);
  assign complete          = sample_count_next >= n_eff;

  assign job_push       = accept && complete;
  assign job_data.sum   = sample_sum_next;
  assign job_data.count = n_eff;

  // Accumulator restarts after each handed-off job.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (complete) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sample_sum_next;
        sample_count <= sample_count_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bsg_back.sv =====
// Back end of the gauge: averages, scales to millivolts, interpolates the
// discharge curve and holds the result. Depends on bsg_pkg.
`default_nettype none

module bsg_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bsg_pkg::job_t                     job_data,
  input  wire logic                              job_empty,
  output logic                                   job_pop,
  input  wire logic [bsg_pkg::SCALE_W-1:0]       mv_per_count_q16,
  input  wire logic                              res_pop,
  output logic                                   res_valid,
  output logic [bsg_pkg::MV_W-1:0]               res_mv,
  output logic [bsg_pkg::SOC_W-1:0]              res_soc
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_AVG_DIV = 3'd1;
  localparam logic [2:0] ST_SCALE   = 3'd2;
  localparam logic [2:0] ST_SEARCH  = 3'd3;
  localparam logic [2:0] ST_INTERP  = 3'd4;
  localparam logic [2:0] ST_SOC_DIV = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  localparam logic [bsg_pkg::MV_W-1:0] CURVE_LO = bsg_pkg::curve_mv(bsg_pkg::SEG_W'(0));
  localparam logic [bsg_pkg::MV_W-1:0] CURVE_HI =
    bsg_pkg::curve_mv(bsg_pkg::SEG_W'(bsg_pkg::SEGMENTS));

  logic [2:0]                     state;
  logic [2:0]                     state_next;

  // Shared shift-subtract divider.
  logic [bsg_pkg::DIV_W-1:0]      rem;
  logic [bsg_pkg::DIV_W-1:0]      dsh;
  logic [bsg_pkg::AVG_W-1:0]      quo;
  logic [bsg_pkg::STEP_W-1:0]     steps;
  logic                           div_ge;
  logic [bsg_pkg::DIV_W-1:0]      rem_step;
  logic [bsg_pkg::AVG_W-1:0]      quo_step;

  // Datapath registers.
  logic [bsg_pkg::MV_W-1:0]       mv;
  logic [bsg_pkg::SEG_W-1:0]      seg;
  logic [bsg_pkg::DX_W-1:0]       offset;

  logic [bsg_pkg::PROD_W-1:0]     prod;
  logic [bsg_pkg::PROD_W-17:0]    prod_mv;
  logic [bsg_pkg::MV_W-1:0]       mv_clamped;
  logic [bsg_pkg::MV_W-1:0]       mv_on_curve;
  logic [bsg_pkg::SEG_W-1:0]      seg_found;
  logic [bsg_pkg::MV_W-1:0]       offset_full;
  logic [bsg_pkg::NUM_W-1:0]      num;
  logic [bsg_pkg::DIV_W-1:0]      soc_dividend;
  logic [bsg_pkg::DIV_W-1:0]      soc_divisor;
  logic                           avg_positive;
  logic                           res_free;
  logic [bsg_pkg::SOC_W-1:0]      soc_q;

  assign res_free = !res_valid || res_pop;
  assign job_pop  = (state == ST_IDLE) && !job_empty;
  assign avg_positive = !job_data.sum[bsg_pkg::SUM_W-1] && (job_data.sum != '0);

  // One divider step: subtract the shifted divisor where it fits.
  assign div_ge   = rem >= dsh;
  assign rem_step = div_ge ? rem - dsh : rem;
  assign quo_step = {quo[bsg_pkg::AVG_W-2:0], div_ge};

  // Scale the average to millivolts; the product is registered as mv.
  assign prod    = bsg_pkg::PROD_W'(quo) * bsg_pkg::PROD_W'(mv_per_count_q16);
  assign prod_mv = prod[bsg_pkg::PROD_W-1:16];
  assign mv_clamped = (prod_mv > (bsg_pkg::PROD_W-16)'(bsg_pkg::MV_MAX)) ?
                      bsg_pkg::MV_MAX : prod_mv[bsg_pkg::MV_W-1:0];

  // Pin the voltage to the curve ends, then find the first segment holding it.
  always_comb begin
    if (mv < CURVE_LO) mv_on_curve = CURVE_LO;
    else if (mv > CURVE_HI) mv_on_curve = CURVE_HI;
    else mv_on_curve = mv;
    seg_found = bsg_pkg::SEG_W'(bsg_pkg::SEGMENTS - 1);
    for (int i = bsg_pkg::SEGMENTS - 1; i >= 0; i--) begin
      if (mv_on_curve <= bsg_pkg::curve_mv(bsg_pkg::SEG_W'(i + 1)))
        seg_found = bsg_pkg::SEG_W'(i);
    end
  end
  assign offset_full = mv_on_curve - bsg_pkg::curve_mv(seg_found);

  // Rounded charge is (2 num + 10 d) / (20 d), with num = y0 d + t dy.
  assign num = bsg_pkg::seg_base(seg) +
               bsg_pkg::NUM_W'(offset) * bsg_pkg::NUM_W'(bsg_pkg::seg_dy(seg));
  assign soc_dividend = {num, 1'b0} +
                        bsg_pkg::DIV_W'(bsg_pkg::seg_dx(seg)) * bsg_pkg::DIV_W'(10);
  assign soc_divisor  = (bsg_pkg::DIV_W'(bsg_pkg::seg_dx(seg)) * bsg_pkg::DIV_W'(20))
                        << (bsg_pkg::SOC_STEPS - 1);

  assign soc_q = (quo[bsg_pkg::SOC_W-1:0] > bsg_pkg::SOC_MAX) ?
                 bsg_pkg::SOC_MAX : quo[bsg_pkg::SOC_W-1:0];

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!job_empty) state_next = avg_positive ? ST_AVG_DIV : ST_SCALE;
      end
      ST_AVG_DIV: begin
        if (steps == bsg_pkg::STEP_W'(1)) state_next = ST_SCALE;
      end
      ST_SCALE:  state_next = ST_SEARCH;
      ST_SEARCH: state_next = ST_INTERP;
      ST_INTERP: state_next = ST_SOC_DIV;
      ST_SOC_DIV: begin
        if (steps == bsg_pkg::STEP_W'(1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Divider and datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rem   <= bsg_pkg::DIV_W'(unsigned'(job_data.sum));
        dsh   <= bsg_pkg::DIV_W'(job_data.count) << (bsg_pkg::AVG_STEPS - 1);
        steps <= bsg_pkg::STEP_W'(bsg_pkg::AVG_STEPS);
        quo   <= '0;
      end
      ST_AVG_DIV, ST_SOC_DIV: begin
        rem   <= rem_step;
        dsh   <= dsh >> 1;
        quo   <= quo_step;
        steps <= steps - bsg_pkg::STEP_W'(1);
      end
      ST_SCALE: mv <= mv_clamped;
      ST_SEARCH: begin
        seg    <= seg_found;
        offset <= offset_full[bsg_pkg::DX_W-1:0];
      end
      ST_INTERP: begin
        rem   <= soc_dividend;
        dsh   <= soc_divisor;
        steps <= bsg_pkg::STEP_W'(bsg_pkg::SOC_STEPS);
        quo   <= '0;
      end
      default: ;
    endcase
  end

  // Result register: one transfer waits here while the next job runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && res_free) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && res_free) begin
      res_mv  <= mv;
      res_soc <= soc_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/battery_soc_gauge_unit.sv =====
// Top level of the battery voltage and state-of-charge gauge.
// Depends on bsg_pkg, bsg_front, bsg_queue and bsg_back.
//
// Signed ADC samples are taken one per cycle while full is low and summed;
// each time the configured count is reached the sum goes into a two-entry
// job queue. The back end turns each job into a voltage in millivolts and a
// state of charge in whole percent, interpolated on a fixed 15-point
// discharge curve and rounded half up. The back end uses a shared
// shift-subtract divider (13 steps for the average, 7 for the charge) and
// skips the average division when the sum is not positive; a finished result
// waits in an output register while the next job runs. Configuration writes
// are always ready and should be issued while the block is idle.
`default_nettype none

module battery_soc_gauge_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // Sample queue side.
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic signed [bsg_pkg::SAMPLE_BITS-1:0] sample,
  // Result queue side.
  output logic                                        empty,
  input  wire logic                                   pop,
  output logic [bsg_pkg::MV_W-1:0]                    voltage_mv,
  output logic [bsg_pkg::SOC_W-1:0]                   soc_percent,
  // Configuration writes.
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic                                   cfg_index,
  input  wire logic [bsg_pkg::SCALE_W-1:0]            cfg_data
);

  logic [bsg_pkg::SPR_W-1:0]   samples_per_result;
  logic [bsg_pkg::SCALE_W-1:0] mv_per_count_q16;
  logic                        job_push;
  logic                        job_full;
  logic                        job_pop;
  logic                        job_empty;
  bsg_pkg::job_t               job_in;
  bsg_pkg::job_t               job_out;
  logic                        res_valid;
  logic                        res_pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_result <= bsg_pkg::SPR_RESET;
      mv_per_count_q16   <= bsg_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsg_pkg::REG_SAMPLES: samples_per_result <= cfg_data[bsg_pkg::SPR_W-1:0];
        bsg_pkg::REG_SCALE:   mv_per_count_q16   <= cfg_data;
        default: ;
      endcase
    end
  end

  bsg_front u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .sample             (sample),
    .full               (full),
    .samples_per_result (samples_per_result),
    .job_push           (job_push),
    .job_data           (job_in),
    .job_full           (job_full)
  );

  bsg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  bsg_back u_back (
    .clk              (clk),
    .rst              (rst),
    .job_data         (job_out),
    .job_empty        (job_empty),
    .job_pop          (job_pop),
    .mv_per_count_q16 (mv_per_count_q16),
    .res_pop          (res_pop),
    .res_valid        (res_valid),
    .res_mv           (voltage_mv),
    .res_soc          (soc_percent)
  );

  // Result transfer.
  assign empty   = !res_valid;
  assign res_pop = pop && res_valid;

endmodule

`default_nettype wire

// ===== tb/tb_battery_soc_gauge_unit.sv =====
// Self-checking testbench for battery_soc_gauge_unit: drives signed ADC samples
// and register writes, predicts voltage and charge, and checks every result.
// Depends on bsg_pkg for widths and register indexes, and on the gauge RTL.
`default_nettype none

module tb_battery_soc_gauge_unit;

  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_STALL    = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 64;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [bsg_pkg::MV_W-1:0]  mv;
    logic [bsg_pkg::SOC_W-1:0] soc;
  } reading_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic                            reg_idx;
    logic [bsg_pkg::SCALE_W-1:0]     data;
    logic [bsg_pkg::SAMPLE_BITS-1:0] smp;
    logic                            typed;
    reading_t                        want;
  } stim_row_t;

  // Clock, reset and block inputs, all known from time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic signed [bsg_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [bsg_pkg::SCALE_W-1:0] cfg_data = '0;
  logic full, empty, cfg_ready;
  logic [bsg_pkg::MV_W-1:0] voltage_mv;
  logic [bsg_pkg::SOC_W-1:0] soc_percent;

  always #4 clk = ~clk;

  battery_soc_gauge_unit dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .voltage_mv(voltage_mv), .soc_percent(soc_percent),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: its own copy of the registers and the accumulator.
  logic [bsg_pkg::SPR_W-1:0]   gauge_spr   = bsg_pkg::SPR_W'(5);
  logic [bsg_pkg::SCALE_W-1:0] gauge_scale = bsg_pkg::SCALE_W'(360300);
  int acc_sum = 0;
  int acc_cnt = 0;

  reading_t pending_readings[$];
  reading_t oldest;
  stim_row_t directed_rows[$];

  int err_count = 0;
  int samples_sent = 0;
  int readings_checked = 0;
  int writes_done = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_request = 1'b0;

  // Discharge curve knees, millivolts and tenths of a percent.
  function automatic int knee_mv(input int i);
    case (i)
      0: return 3000;   1: return 3200;   2: return 3300;   3: return 3400;
      4: return 3500;   5: return 3550;   6: return 3600;   7: return 3650;
      8: return 3700;   9: return 3800;  10: return 3900;  11: return 4050;
      12: return 4100; 13: return 4150;
      default: return 4200;
    endcase
  endfunction

  function automatic int knee_tenths(input int i);
    case (i)
      0: return 0;     1: return 20;    2: return 37;    3: return 62;
      4: return 120;   5: return 177;   6: return 255;   7: return 370;
      8: return 485;   9: return 650;  10: return 760;  11: return 893;
      12: return 930; 13: return 970;
      default: return 1000;
    endcase
  endfunction

  function automatic int tenths_rounded(input int t);
    int p;
    p = (t + 5) / 10;
    return (p > 100) ? 100 : p;
  endfunction

  // Charge in whole percent: first segment holding the voltage, rounded half up.
  function automatic int charge_percent(input int mv);
    int i, x0, x1, y0, y1;
    longint d, num, p;
    if (mv > knee_mv(bsg_pkg::TABLE_POINTS - 1))
      return tenths_rounded(knee_tenths(bsg_pkg::TABLE_POINTS - 1));
    if (mv < knee_mv(0)) return tenths_rounded(knee_tenths(0));
    for (i = 0; i < bsg_pkg::TABLE_POINTS - 1; i++) begin
      x0 = knee_mv(i);
      x1 = knee_mv(i + 1);
      y0 = knee_tenths(i);
      y1 = knee_tenths(i + 1);
      if (x0 <= mv && x1 >= mv) begin
        if (mv <= x0) return tenths_rounded(y0);
        if (mv >= x1) return tenths_rounded(y1);
        d = x1 - x0;
        num = longint'(y0) * d + longint'(mv - x0) * longint'(y1 - y0);
        if (num < 0) num = 0;
        p = (num * 2 + d * 10) / (d * 20);
        return (p > 100) ? 100 : int'(p);
      end
    end
    return tenths_rounded(knee_tenths(bsg_pkg::TABLE_POINTS - 1));
  endfunction

  // Accumulate one sample; returns 1 when an average completes a reading.
  function automatic bit gauge_sample(input logic signed [bsg_pkg::SAMPLE_BITS-1:0] s,
                                      output reading_t r);
    int n, avg;
    longint mvl;
    n = int'(gauge_spr);
    if (n == 0) n = 1;
    if (n > bsg_pkg::MAX_AVERAGE) n = bsg_pkg::MAX_AVERAGE;
    acc_sum += int'(s);
    acc_cnt++;
    r = '0;
    if (acc_cnt < n) return 1'b0;
    avg = (acc_sum > 0) ? acc_sum / n : 0;
    acc_sum = 0;
    acc_cnt = 0;
    mvl = (longint'(avg) * longint'(gauge_scale)) >>> 16;
    if (mvl > 16383) mvl = 16383;
    r.mv  = bsg_pkg::MV_W'(mvl);
    r.soc = bsg_pkg::SOC_W'(charge_percent(int'(mvl)));
    return 1'b1;
  endfunction

  // Result side: check each transfer against the oldest expected reading.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      readings_checked++;
      if (pending_readings.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected reading voltage_mv %0d soc_percent %0d",
                   $time, voltage_mv, soc_percent);
      end else begin
        oldest = pending_readings.pop_front();
        if (voltage_mv !== oldest.mv) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: voltage_mv expected %0d actual %0d", $time, oldest.mv, voltage_mv);
        end
        if (soc_percent !== oldest.soc) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: soc_percent expected %0d actual %0d",
                     $time, oldest.soc, soc_percent);
        end
      end
    end
  end

  // Result side: random pop, with one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_left = LONG_STALL;
        stall_request = 1'b0;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one sample until it transfers, then predict its reading.
  task automatic send_sample(input logic signed [bsg_pkg::SAMPLE_BITS-1:0] value,
                             input logic typed, input reading_t typed_want);
    reading_t r;
    bit got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push   <= 1'b1;
    sample <= value;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    samples_sent++;
    got = gauge_sample(value, r);
    if (typed) begin
      r   = typed_want;
      got = 1'b1;
    end
    if (got) pending_readings.push_back(r);
  endtask

  // Drop push, wait for every expected reading, then let the back end settle.
  task automatic wait_settled();
    @(negedge clk);
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write transfer; the predictor follows it.
  task automatic write_reg(input logic idx, input logic [bsg_pkg::SCALE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    writes_done++;
    if (idx == bsg_pkg::REG_SAMPLES) gauge_spr = data[bsg_pkg::SPR_W-1:0];
    else gauge_scale = data;
  endtask

  task automatic add_write(input logic idx, input int data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.data = bsg_pkg::SCALE_W'(data);
    directed_rows.push_back(row);
  endtask

  task automatic add_sample(input int value, input logic typed, input int mv, input int soc);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.smp = bsg_pkg::SAMPLE_BITS'(value);
    row.typed = typed;
    row.want.mv = bsg_pkg::MV_W'(mv);
    row.want.soc = bsg_pkg::SOC_W'(soc);
    directed_rows.push_back(row);
  endtask

  // Random sample: mostly voltages around the curve, some noise and near-ground values.
  function automatic logic signed [bsg_pkg::SAMPLE_BITS-1:0] pick_sample();
    int r, target, v;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      v = int'($urandom_range(0, 16)) - 8;
    end else if (r < 30 || gauge_scale == 0) begin
      v = int'($urandom_range(0, 2047)) - 1024;
    end else begin
      target = $urandom_range(2900, 4300);
      v = int'((longint'(target) << 16) / longint'(gauge_scale));
      v = v + int'($urandom_range(0, 4)) - 2;
      if (v > 1023) v = 1023;
    end
    return bsg_pkg::SAMPLE_BITS'(v);
  endfunction

  function automatic logic [bsg_pkg::SCALE_W-1:0] pick_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return bsg_pkg::SCALE_W'($urandom_range(3, 5) << 16);
    if (r < 5) return bsg_pkg::SCALE_W'(340300 + $urandom_range(0, 40000));
    return bsg_pkg::SCALE_W'($urandom);
  endfunction

  // Main stimulus: reset, directed rows, then random phases.
  initial begin
    int p, k;
    logic [bsg_pkg::SCALE_W-1:0] spr_word, scale_word;

    // Reset values of both registers, then quick mode on exact curve knees.
    for (k = 0; k < 4; k++) add_sample(1023, 1'b0, 0, 0);
    add_sample(1023, 1'b1, 5624, 100);
    add_write(bsg_pkg::REG_SAMPLES, 1);
    add_write(bsg_pkg::REG_SCALE, 262144);
    add_sample(750, 1'b1, 3000, 0);
    add_sample(925, 1'b1, 3700, 49);
    add_sample(800, 1'b1, 3200, 2);
    add_sample(-1024, 1'b1, 0, 0);
    add_sample(-1, 1'b1, 0, 0);
    add_sample(1000, 1'b0, 0, 0);
    add_sample(1023, 1'b0, 0, 0);
    // Largest and zero scale.
    add_write(bsg_pkg::REG_SCALE, 20'hFFFFF);
    add_sample(1023, 1'b1, 16367, 100);
    add_write(bsg_pkg::REG_SCALE, 0);
    add_sample(1023, 1'b1, 0, 0);
    // A count of zero acts as one.
    add_write(bsg_pkg::REG_SAMPLES, 0);
    add_write(bsg_pkg::REG_SCALE, 262144);
    add_sample(900, 1'b1, 3600, 26);
    // A count above the limit acts as the limit; the negative sum clamps to zero.
    add_write(bsg_pkg::REG_SAMPLES, 20'hFFFFF);
    for (k = 0; k < 7; k++) add_sample((k % 2 == 0) ? -1024 : 1023, 1'b0, 0, 0);
    add_sample(1023, 1'b1, 0, 0);
    // Count lowered midway: the next sample completes a triple sum, voltage saturates.
    add_write(bsg_pkg::REG_SAMPLES, 3);
    add_write(bsg_pkg::REG_SCALE, 20'hFFFFF);
    add_sample(1023, 1'b0, 0, 0);
    add_sample(1023, 1'b0, 0, 0);
    add_write(bsg_pkg::REG_SAMPLES, 1);
    add_sample(1023, 1'b1, 16383, 100);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_settled();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].data);
      end else begin
        send_sample($signed(directed_rows[i].smp), directed_rows[i].typed,
                    directed_rows[i].want);
      end
    end

    // Random phases, each with a fresh setting of both registers.
    for (p = 0; p < PHASES; p++) begin
      wait_settled();
      if (p < 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 65;
      end else if (p < 6) begin
        send_idle_pct = 65;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      spr_word = bsg_pkg::SCALE_W'($urandom);
      case (p)
        0: spr_word[bsg_pkg::SPR_W-1:0] = bsg_pkg::SPR_W'(1);
        1: spr_word[bsg_pkg::SPR_W-1:0] = bsg_pkg::SPR_W'(8);
        2: spr_word[bsg_pkg::SPR_W-1:0] = bsg_pkg::SPR_W'(0);
        3: spr_word[bsg_pkg::SPR_W-1:0] = bsg_pkg::SPR_W'(15);
        default: spr_word[bsg_pkg::SPR_W-1:0] = bsg_pkg::SPR_W'($urandom_range(0, 15));
      endcase
      case (p)
        0: scale_word = bsg_pkg::SCALE_W'(262144);
        1: scale_word = bsg_pkg::SCALE_W'(360300);
        2: scale_word = 20'hFFFFF;
        4: scale_word = '0;
        default: scale_word = pick_scale();
      endcase
      write_reg(bsg_pkg::REG_SAMPLES, spr_word);
      write_reg(bsg_pkg::REG_SCALE, scale_word);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Quick mode fills the block while the receiver holds off.
        if (p == 0 && k == 10) stall_request = 1'b1;
        // The sender pauses once until every reading has come out.
        if (p == 5 && k == PHASE_ITEMS / 2) wait_settled();
        send_sample(pick_sample(), 1'b0, '0);
      end
    end

    wait_settled();
    $display("Run covered %0d samples and %0d readings over %0d register writes,",
             samples_sent, readings_checked, writes_done);
    $display("with quick, averaged and saturated settings under both idling patterns.");
    if (err_count == 0 && pending_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
